// ----- src/nmb_pkg.sv -----
package nmb_pkg;

    // Widths fixed by the pixel format and the frame size registers
    localparam int PIX_W        = 8;
    localparam int CFG_W        = 11;
    localparam int CFG_INDEX_W  = 1;
    localparam int AREA_W       = 2 * CFG_W;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // Depth of the queue between the parts and of the result queue
    localparam int QUEUE_DEPTH  = 4;
    localparam int LEVEL_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic             flush_only;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             frame_last;
    } pixel_out_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

    // Classified word handed from the front to the back
    typedef struct packed {
        logic [CFG_W-1:0] col;
        rgb_t             px;
        logic             emit;
        logic             interior;
        logic             last;
    } work_t;

endpackage

// ----- src/neighbour_mean_blur_3x3.sv -----
// Neighbour-mean 3x3 blur on an RGB pixel stream.
// Input: pixels of a frame in raster order are written with push while full is low.
// flush_only words after the final pixel of the frame drain the window; a flush
// word during the frame is taken and dropped. Results are read like a queue:
// while empty is low the oldest pixel stands on pixel_out and pop takes it.
// Frame size comes from cfg_write / cfg_index / cfg_data (index 0 width,
// index 1 height); full stays high for the cycle after a write.
// The pixel that an accepted word releases is the one that came image_width + 1
// words earlier in the frame, so the first image_width + 1 words of a frame give
// no result. Throughput is one word per cycle while the receiver keeps up and no
// register write holds input off: the line store in the back part takes one read
// and one write per cycle, one of each for every word.
// Reset empties both queues, restores 640 x 480 and restarts the frame; no
// clearing pass is needed. When the receiver stalls, the result queue fills,
// then the inner queue, and full rises; nothing is lost.
module neighbour_mean_blur_3x3
    import nmb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  pixel_in_t              pixel_in,
    output logic                   empty,
    input  logic                   pop,
    output pixel_out_t             pixel_out,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic               mid_full;
    logic               mid_empty;
    logic               mid_push;
    logic               mid_pop;
    work_t              mid_in;
    work_t              mid_out;
    logic               result_push;
    pixel_out_t         result_word;
    logic [LEVEL_W-1:0] out_level;

    // Classify incoming words and track frame position
    nmb_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mid_full  (mid_full),
        .work_push (mid_push),
        .work_word (mid_in)
    );

    // Decouple the front from the back
    nmb_fifo #(
        .WIDTH ($bits(work_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_in),
        .pop       (mid_pop),
        .pop_data  (mid_out),
        .empty     (mid_empty),
        .full      (mid_full),
        .level     ()
    );

    // Line store, window and filter
    nmb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .work_valid  (!mid_empty),
        .work_word   (mid_out),
        .work_pop    (mid_pop),
        .out_level   (out_level),
        .result_push (result_push),
        .result_word (result_word)
    );

    // Hold results for the receiver
    nmb_fifo #(
        .WIDTH ($bits(pixel_out_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (result_push),
        .push_data (result_word),
        .pop       (pop),
        .pop_data  (pixel_out),
        .empty     (empty),
        .full      (),
        .level     (out_level)
    );

endmodule

// ----- src/nmb_fifo.sv -----
module nmb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic [WIDTH-1:0]             push_data,
    input  logic                         pop,
    output logic [WIDTH-1:0]             pop_data,
    output logic                         empty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             do_push;
    logic             do_pop;

    assign empty    = (level_reg == '0);
    assign full     = (level_reg == LVL_W'(DEPTH));
    assign level    = level_reg;
    assign pop_data = slot[head_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        level_next = level_reg;
        if (do_pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (do_push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            level_reg <= level_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot[tail_reg] <= push_data;
        end
    end

endmodule

// ----- src/nmb_front.sv -----
module nmb_front
    import nmb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  pixel_in_t              pixel_in,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   mid_full,
    output logic                   work_push,
    output work_t                  work_word
);

    localparam int WIDTH_CAP = (MAX_WIDTH < (1 << CFG_W) - 1) ? MAX_WIDTH : (1 << CFG_W) - 1;

    logic [CFG_W-1:0]  width_reg, width_next;
    logic [CFG_W-1:0]  height_reg, height_next;
    logic [AREA_W-1:0] area_reg;
    logic              settle_reg;
    logic [CFG_W-1:0]  column_reg, column_next;
    logic [CFG_W-1:0]  row_reg, row_next;
    logic [AREA_W-1:0] count_reg, count_next;

    logic [CFG_W-1:0]  eff_w;
    logic [CFG_W-1:0]  eff_h;
    logic              accept;
    logic              draining;
    logic              take;
    logic [CFG_W:0]    col_inc;
    logic [AREA_W-1:0] count_inc;
    logic              emit;
    logic              interior;
    logic              last;

    // Clamp the frame size registers to the supported range
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = CFG_W'(1);
        end
        else if (width_reg > CFG_W'(WIDTH_CAP))
        begin
            eff_w = CFG_W'(WIDTH_CAP);
        end
        else
        begin
            eff_w = width_reg;
        end
        if (height_reg == '0)
        begin
            eff_h = CFG_W'(1);
        end
        else if (height_reg > CFG_W'(HEIGHT_LIMIT))
        begin
            eff_h = CFG_W'(HEIGHT_LIMIT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    // Hold input off in the cycle after a register write so the frame area settles
    assign full     = mid_full || settle_reg;
    assign accept   = push && !full;
    assign draining = (row_reg >= eff_h);
    assign take     = accept && !(pixel_in.flush_only && !draining);

    // Classify the word: does it release a pixel, and is that pixel inside the border
    assign col_inc   = {1'b0, column_reg} + 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign emit      = (row_reg >= CFG_W'(2))
                    || ((row_reg == CFG_W'(1)) && (column_reg != '0))
                    || ((row_reg == '0) && (column_reg > eff_w));
    assign interior  = (row_reg >= CFG_W'(2)) && !draining && (column_reg >= CFG_W'(2));
    assign last      = emit && (count_inc >= area_reg);

    always_comb
    begin
        work_push          = take;
        work_word.col      = column_reg;
        work_word.px.red   = draining ? '0 : pixel_in.red_in;
        work_word.px.green = draining ? '0 : pixel_in.green_in;
        work_word.px.blue  = draining ? '0 : pixel_in.blue_in;
        work_word.emit     = emit;
        work_word.interior = interior;
        work_word.last     = last;
    end

    // Advance the frame position; restart after the final pixel
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        count_next  = count_reg;
        if (take)
        begin
            if (col_inc >= {1'b0, eff_w})
            begin
                column_next = '0;
                row_next    = row_reg + 1'b1;
            end
            else
            begin
                column_next = col_inc[CFG_W-1:0];
            end
            if (emit)
            begin
                count_next = count_inc;
            end
            if (last)
            begin
                column_next = '0;
                row_next    = '0;
                count_next  = '0;
            end
        end
    end

    // Decode register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data;
                REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(RESET_WIDTH);
            height_reg <= CFG_W'(RESET_HEIGHT);
            area_reg   <= AREA_W'(RESET_WIDTH * RESET_HEIGHT);
            settle_reg <= 1'b0;
            column_reg <= '0;
            row_reg    <= '0;
            count_reg  <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            area_reg   <= AREA_W'(eff_w) * AREA_W'(eff_h);
            settle_reg <= cfg_write;
            column_reg <= column_next;
            row_reg    <= row_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/nmb_back.sv -----
module nmb_back
    import nmb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               work_valid,
    input  work_t              work_word,
    output logic               work_pop,
    input  logic [LEVEL_W-1:0] out_level,
    output logic               result_push,
    output pixel_out_t         result_word
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    typedef struct packed {
        rgb_t upper;
        rgb_t middle;
    } line_pair_t;

    line_pair_t        line_mem [MAX_WIDTH];
    line_pair_t        rd_reg;
    line_pair_t        fwd_data_reg;
    logic              fwd_sel_reg;
    work_t             s1_word_reg;
    logic              s1_valid_reg, s1_valid_next;
    rgb_t              win_reg [3][2];

    line_pair_t        rd;
    line_pair_t        wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    rgb_t              fresh [3];
    rgb_t              nb [8];
    rgb_t              mean;
    logic [PIX_W-1:0]  sum_r, sum_g, sum_b;

    // Take a word only when the result queue has room for it
    assign work_pop = work_valid
                   && (((LEVEL_W + 1)'(out_level) + (LEVEL_W + 1)'(s1_valid_reg))
                       < (LEVEL_W + 1)'(QUEUE_DEPTH));
    assign s1_valid_next = work_pop;

    // Line store: read at pop, write back in the cycle after; forward on a same-column hit
    assign rd_addr = ADDR_W'(work_word.col);
    assign wr_addr = ADDR_W'(s1_word_reg.col);
    assign rd      = fwd_sel_reg ? fwd_data_reg : rd_reg;
    assign wr_data = '{upper: rd.middle, middle: s1_word_reg.px};

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (work_pop)
        begin
            rd_reg       <= line_mem[rd_addr];
            fwd_sel_reg  <= s1_valid_reg && (s1_word_reg.col == work_word.col);
            fwd_data_reg <= wr_data;
            s1_word_reg  <= work_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Shift the window by one column
    assign fresh[0] = rd.upper;
    assign fresh[1] = rd.middle;
    assign fresh[2] = s1_word_reg.px;

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= fresh[r];
            end
        end
    end

    // Gather the eight neighbours of the centre after the shift
    assign nb[0] = win_reg[0][0];
    assign nb[1] = win_reg[0][1];
    assign nb[2] = fresh[0];
    assign nb[3] = win_reg[1][0];
    assign nb[4] = fresh[1];
    assign nb[5] = win_reg[2][0];
    assign nb[6] = win_reg[2][1];
    assign nb[7] = fresh[2];

    // Sum each neighbour divided by eight, per channel
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum_r = sum_r + PIX_W'(nb[i].red[PIX_W-1:3]);
            sum_g = sum_g + PIX_W'(nb[i].green[PIX_W-1:3]);
            sum_b = sum_b + PIX_W'(nb[i].blue[PIX_W-1:3]);
        end
        mean.red   = sum_r;
        mean.green = sum_g;
        mean.blue  = sum_b;
    end

    // Pass border pixels through, filter the interior
    always_comb
    begin
        result_push           = s1_valid_reg && s1_word_reg.emit;
        result_word.red_out   = s1_word_reg.interior ? mean.red   : win_reg[1][1].red;
        result_word.green_out = s1_word_reg.interior ? mean.green : win_reg[1][1].green;
        result_word.blue_out  = s1_word_reg.interior ? mean.blue  : win_reg[1][1].blue;
        result_word.frame_last = s1_word_reg.last;
    end

endmodule

// ----- src/nmb_checker.sv -----
module nmb_checker
    import nmb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   push,
    input logic                   full,
    input pixel_in_t              pixel_in,
    input logic                   empty,
    input logic                   pop,
    input pixel_out_t             pixel_out,
    input logic                   cfg_write,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]       cfg_data
);

    // Input is held off for the cycle after a register write
    a_cfg_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_write |=> full
    ) else $error("input open right after a register write");

    // A waiting word stays put while the receiver stalls
    a_stall_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(pixel_out))
    ) else $error("waiting result changed or vanished under stall");

    // Reset leaves nothing to read
    a_reset_empty: assert property (
        @(posedge clk)
        !rst_n |-> empty
    ) else $error("result present during reset");

endmodule

bind neighbour_mean_blur_3x3 nmb_checker u_checker (.*);

// ----- test/neighbour_mean_blur_3x3_test.sv -----
`timescale 1ns / 1ps

module neighbour_mean_blur_3x3_test;
    import nmb_pkg::*;

    localparam int MAX_W = 1024;

    typedef enum int {FILL_RANDOM, FILL_WHITE, FILL_BLACK, FILL_CHECKER} fill_t;

    logic             clk;
    logic             rst_n;
    logic             push;
    logic             full;
    pixel_in_t        pixel_in;
    logic             empty;
    logic             pop;
    pixel_out_t       pixel_out;
    logic             cfg_write;
    cfg_reg_t         cfg_index;
    logic [CFG_W-1:0] cfg_data;

    neighbour_mean_blur_3x3 #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .pixel_in  (pixel_in),
        .empty     (empty),
        .pop       (pop),
        .pixel_out (pixel_out),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the blur: line stores, window, frame position and size
    rgb_t             upper_line [MAX_W];
    rgb_t             middle_line [MAX_W];
    rgb_t             window_px [3][3];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      sent_pixels;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    pixel_out_t       pending_pixels [$];
    pixel_out_t       head_pixel;
    int unsigned      taken_words;
    int unsigned      fail_count;
    bit               idle_on;
    bit               rx_hold;
    int unsigned      rx_gap;

    always #2 clk = ~clk;

    function automatic int unsigned frame_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned frame_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > HEIGHT_LIMIT)
            return HEIGHT_LIMIT;
        return height_reg;
    endfunction

    // Sum of each neighbour divided by eight, centre left out
    function automatic rgb_t neighbour_mean();
        int unsigned r_acc;
        int unsigned g_acc;
        int unsigned b_acc;
        rgb_t        mean;
        r_acc = 0;
        g_acc = 0;
        b_acc = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                if (!(r == 1 && c == 1))
                begin
                    r_acc += window_px[r][c].red >> 3;
                    g_acc += window_px[r][c].green >> 3;
                    b_acc += window_px[r][c].blue >> 3;
                end
        mean.red   = 8'(r_acc);
        mean.green = 8'(g_acc);
        mean.blue  = 8'(b_acc);
        return mean;
    endfunction

    // Advance the shadow by one accepted word; queue the pixel it releases
    function automatic void predict_blurred_pixel(pixel_in_t word);
        int unsigned wd;
        int unsigned ht;
        int unsigned c;
        bit          draining;
        bit          release_px;
        bit          interior;
        rgb_t        px;
        rgb_t        shown;
        pixel_out_t  res;
        wd = frame_width();
        ht = frame_height();
        draining = row_pos >= ht;
        // drop a flush inside the frame
        if (!draining && word.flush_only)
            return;
        taken_words++;
        px = draining ? '0 : {word.red_in, word.green_in, word.blue_in};
        c = (col_pos >= MAX_W) ? 0 : col_pos;
        for (int r = 0; r < 3; r++)
        begin
            window_px[r][0] = window_px[r][1];
            window_px[r][1] = window_px[r][2];
        end
        window_px[0][2] = upper_line[c];
        window_px[1][2] = middle_line[c];
        window_px[2][2] = px;
        upper_line[c]   = middle_line[c];
        middle_line[c]  = px;

        release_px = row_pos * wd + col_pos >= wd + 1;
        interior   = row_pos >= 2 && row_pos + 1 <= ht && col_pos >= 2;
        col_pos++;
        if (col_pos >= wd)
        begin
            col_pos = 0;
            row_pos++;
        end
        if (!release_px)
            return;

        shown = interior ? neighbour_mean() : window_px[1][1];
        res.red_out    = shown.red;
        res.green_out  = shown.green;
        res.blue_out   = shown.blue;
        res.frame_last = 1'b0;
        sent_pixels++;
        // restart the frame after its final pixel
        if (sent_pixels >= wd * ht)
        begin
            res.frame_last = 1'b1;
            col_pos = 0;
            row_pos = 0;
            sent_pixels = 0;
        end
        pending_pixels.push_back(res);
    endfunction

    // Offer one word until the block takes it; called at a falling edge
    task automatic push_word(input pixel_in_t word);
        if (idle_on && $urandom_range(0, 15) == 0)
        begin
            push = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        push = 1'b1;
        pixel_in = word;
        do
            @(posedge clk);
        while (full);
        predict_blurred_pixel(word);
        @(negedge clk);
        push = 1'b0;
    endtask

    // Wait for every pixel to come out, then let the pipeline settle
    task automatic wait_drained();
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_frame_size(input int unsigned wd, input int unsigned ht);
        cfg_write = 1'b1;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = CFG_W'(wd);
        @(negedge clk);
        width_reg = CFG_W'(wd);
        cfg_index = REG_IMAGE_HEIGHT;
        cfg_data  = CFG_W'(ht);
        @(negedge clk);
        height_reg = CFG_W'(ht);
        cfg_write = 1'b0;
    endtask

    // One frame in raster order, then the drain words;
    // noise_pct sets stray flushes in the frame and pixels among the drain
    task automatic send_frame(input fill_t fill, input int unsigned noise_pct);
        int unsigned wd;
        int unsigned ht;
        pixel_in_t   word;
        logic [7:0]  level;
        wd = frame_width();
        ht = frame_height();
        for (int unsigned i = 0; i < wd * ht; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                {word.red_in, word.green_in, word.blue_in} = 24'($urandom);
                word.flush_only = 1'b1;
                push_word(word);
            end
            {word.red_in, word.green_in, word.blue_in} = 24'($urandom);
            case (fill)
                FILL_WHITE:
                    {word.red_in, word.green_in, word.blue_in} = '1;
                FILL_BLACK:
                    {word.red_in, word.green_in, word.blue_in} = '0;
                FILL_CHECKER:
                begin
                    level = (((i / wd) + (i % wd)) & 1) ? 8'hFF : 8'h00;
                    word.red_in   = level;
                    word.green_in = ~level;
                    word.blue_in  = level;
                end
                default:
                    ;
            endcase
            word.flush_only = 1'b0;
            push_word(word);
        end
        for (int unsigned i = 0; i <= wd; i++)
        begin
            {word.red_in, word.green_in, word.blue_in} = 24'($urandom);
            word.flush_only = $urandom_range(0, 99) >= noise_pct;
            push_word(word);
        end
    endtask

    task automatic test_small_frames();
        set_frame_size(3, 3);
        send_frame(FILL_WHITE, 0);
        send_frame(FILL_BLACK, 0);
        send_frame(FILL_CHECKER, 0);
        wait_drained();
        set_frame_size(4, 4);
        send_frame(FILL_RANDOM, 40);
        send_frame(FILL_CHECKER, 20);
        wait_drained();
    endtask

    // Zero and out-of-range sizes, single rows and columns
    task automatic test_size_extremes();
        set_frame_size(0, 0);
        send_frame(FILL_RANDOM, 30);
        wait_drained();
        set_frame_size(1, 5);
        send_frame(FILL_WHITE, 0);
        wait_drained();
        set_frame_size(5, 1);
        send_frame(FILL_RANDOM, 0);
        wait_drained();
        set_frame_size(2, 2);
        send_frame(FILL_CHECKER, 0);
        wait_drained();
        set_frame_size(1, 2047);
        send_frame(FILL_RANDOM, 2);
        wait_drained();
    endtask

    // Hold the receiver so the block backs up and raises full
    task automatic test_input_stall();
        set_frame_size(8, 6);
        fork
            begin
                rx_hold = 1'b1;
                repeat (400) @(negedge clk);
                rx_hold = 1'b0;
            end
            send_frame(FILL_RANDOM, 5);
        join
        wait_drained();
    endtask

    task automatic test_random_frames();
        int unsigned stop_at;
        stop_at = taken_words + 300;
        while (taken_words < stop_at)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                wait_drained();
                if ($urandom_range(0, 99) < 85)
                    set_frame_size($urandom_range(1, 24), $urandom_range(1, 10));
                else
                    set_frame_size($urandom_range(25, 200), $urandom_range(1, 4));
            end
            send_frame(FILL_RANDOM, $urandom_range(0, 10));
        end
        wait_drained();
    endtask

    // Back-to-back frames with no idling on either side
    task automatic test_steady_stream();
        idle_on = 1'b0;
        set_frame_size($urandom_range(3, 16), $urandom_range(3, 8));
        repeat (3) send_frame(FILL_RANDOM, 0);
        wait_drained();
    endtask

    // Receiver: pop with random stall bursts
    initial
    begin
        pop = 1'b0;
        rx_gap = 0;
        forever
        begin
            @(negedge clk);
            if (rx_gap > 0)
            begin
                pop = 1'b0;
                rx_gap--;
            end
            else if (rx_hold)
                pop = 1'b0;
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                pop = 1'b0;
                rx_gap = $urandom_range(1, 12) - 1;
            end
            else
                pop = 1'b1;
        end
    end

    // Compare each word taken with the oldest predicted pixel
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected pixel r=%0d g=%0d b=%0d last=%0b", $realtime,
                             pixel_out.red_out, pixel_out.green_out, pixel_out.blue_out,
                             pixel_out.frame_last);
            end
            else
            begin
                head_pixel = pending_pixels.pop_front();
                if (pixel_out.red_out !== head_pixel.red_out
                    || pixel_out.green_out !== head_pixel.green_out
                    || pixel_out.blue_out !== head_pixel.blue_out
                    || pixel_out.frame_last !== head_pixel.frame_last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b",
                                 $realtime, head_pixel.red_out, head_pixel.green_out,
                                 head_pixel.blue_out, head_pixel.frame_last,
                                 pixel_out.red_out, pixel_out.green_out,
                                 pixel_out.blue_out, pixel_out.frame_last);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pixel_in = '0;
        cfg_write = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data = '0;
        width_reg = CFG_W'(RESET_WIDTH);
        height_reg = CFG_W'(RESET_HEIGHT);
        foreach (upper_line[i])
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        foreach (window_px[r, c])
            window_px[r][c] = '0;
        col_pos = 0;
        row_pos = 0;
        sent_pixels = 0;
        taken_words = 0;
        fail_count = 0;
        idle_on = 1'b1;
        rx_hold = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_small_frames();
        test_size_extremes();
        test_input_stall();
        test_random_frames();
        test_steady_stream();

        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
